// ===== design/hrhp_pkg.sv =====
// Package: constants, types and helpers for the request head parser.
`default_nettype none
package hrhp_pkg;
  localparam int unsigned PosW = 13;
  localparam int unsigned LenW = 14;
  localparam int unsigned LineW = 10;
  localparam logic [PosW:0] BufferBytes = 14'd8192;
  localparam logic [LineW:0] MaxLines = 11'd512;

  localparam logic [7:0] ChCr = 8'h0d;
  localparam logic [7:0] ChLf = 8'h0a;
  localparam logic [7:0] ChSp = 8'h20;
  localparam logic [7:0] ChColon = 8'h3a;

  typedef enum logic [1:0] {
    PH_REQUEST = 2'd0,
    PH_HEADERS = 2'd1,
    PH_DONE    = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_HOST  = 2'd1,
    KIND_AUTH  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_t;

  typedef struct packed {
    logic            request_valid;
    logic            is_get;
    logic [1:0]      version_code;
    logic [PosW-1:0] path_offset;
    logic [LenW-1:0] path_length;
    logic [PosW-1:0] host_offset;
    logic [LenW-1:0] host_length;
    logic [PosW-1:0] auth_offset;
    logic [LenW-1:0] auth_length;
  } res_t;

  // Character of a keyword at index k; its last character past its end (callers also check
  // the index range, so that value is never used there).
  function automatic logic [7:0] get_ch(input logic [1:0] k);
    unique case (k)
      2'd0: get_ch = "G";
      2'd1: get_ch = "E";
      default: get_ch = "T";
    endcase
  endfunction

  function automatic logic [7:0] http_ch(input logic [2:0] k);
    unique case (k)
      3'd0: http_ch = "H";
      3'd1: http_ch = "T";
      3'd2: http_ch = "T";
      3'd3: http_ch = "P";
      default: http_ch = "/";
    endcase
  endfunction

  function automatic logic [7:0] host_ch(input logic [1:0] k);
    unique case (k)
      2'd0: host_ch = "H";
      2'd1: host_ch = "o";
      2'd2: host_ch = "s";
      default: host_ch = "t";
    endcase
  endfunction

  function automatic logic [7:0] auth_ch(input logic [3:0] k);
    unique case (k)
      4'd0: auth_ch = "A";
      4'd1: auth_ch = "u";
      4'd2: auth_ch = "t";
      4'd3: auth_ch = "h";
      4'd4: auth_ch = "o";
      4'd5: auth_ch = "r";
      4'd6: auth_ch = "i";
      4'd7: auth_ch = "z";
      4'd8: auth_ch = "a";
      4'd9: auth_ch = "t";
      4'd10: auth_ch = "i";
      4'd11: auth_ch = "o";
      default: auth_ch = "n";
    endcase
  endfunction

  function automatic logic [7:0] basic_ch(input logic [2:0] k);
    unique case (k)
      3'd0: basic_ch = "B";
      3'd1: basic_ch = "a";
      3'd2: basic_ch = "s";
      3'd3: basic_ch = "i";
      default: basic_ch = "c";
    endcase
  endfunction
endpackage
`default_nettype wire

// ===== design/http_request_head_parser_top.sv =====
// Top level: stream ports, skid-free output register and the parser core.
`default_nettype none
// HTTP request head parser. Feed one request buffer as a byte stream on s_axis
// (tlast on the final byte); one summary request leaves on m_axis after the
// last byte. Throughput is one byte per clock while s_axis_tready is high:
// every byte is handled by the core's state update, and the summary is
// registered as the last byte is taken. s_axis_tready is high while the
// output register is empty or being drained; bytes stall while a summary waits.
module http_request_head_parser_top
  import hrhp_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // data_byte
  input  wire logic         s_axis_tlast,   // last_byte
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // request_valid, is_get, version_code[1:0], path_offset[12:0], path_length[13:0],
  // host_offset[12:0], host_length[13:0], auth_offset[12:0], auth_length[13:0]; zero pad
  output logic [87:0]       m_axis_tdata
);
  logic fire, core_valid, out_q;
  in_t  in_w;
  res_t core_res;

  // accept unless a summary is parked and not being taken
  assign s_axis_tready = !out_q || m_axis_tready;
  assign fire = s_axis_tvalid && s_axis_tready;
  assign in_w = '{data: s_axis_tdata, last: s_axis_tlast};

  hrhp_core u_core (
    .clk_i, .rst_ni, .in_fire_i(fire), .in_i(in_w),
    .res_valid_o(core_valid), .res_o(core_res)
  );

  // hold the result flag until the sink takes it; the core holds data meanwhile
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= 1'b0;
    end else if (core_valid) begin
      out_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_q;
  assign m_axis_tdata = {3'd0, core_res.auth_length, core_res.auth_offset,
                         core_res.host_length, core_res.host_offset,
                         core_res.path_length, core_res.path_offset,
                         core_res.version_code, core_res.is_get, core_res.request_valid};
endmodule
`default_nettype wire

// ===== design/hrhp_core.sv =====
// Parser core: per-byte state update, registered result on the last byte.
`default_nettype none
module hrhp_core
  import hrhp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_fire_i,
  input  in_t       in_i,
  output logic      res_valid_o,
  output res_t      res_o
);
  logic [PosW:0]   pos_q, pos_d;
  logic [PosW:0]   lb_q, lb_d;
  logic [LineW:0]  lines_q, lines_d;
  phase_e          ph_q, ph_d;
  logic            crp_q, crp_d, inw_q, inw_d, err_q, err_d;
  logic [1:0]      wn_q, wn_d;
  logic            mf_q, mf_d, ma_q, ma_d, mp_q, mp_d, m10_q, m10_d, m20_q, m20_d;
  kind_e           kind_q, kind_d;
  logic [PosW+1:0] vb_q, vb_d;
  logic            colon_q, colon_d, spf_q, spf_d, host_q, host_d, getok_q, getok_d;
  logic [PosW:0]   w0_q, w0_d, pb_q, pb_d, pe_q, pe_d, w2_q, w2_d, te_q, te_d;
  logic [1:0]      rk_q, rk_d, ver_q, ver_d;
  logic [PosW:0]   hoff_q, hoff_d, hlen_q, hlen_d, aoff_q, aoff_d, alen_q, alen_d;
  res_t            res_d;

  logic [7:0]      c;
  logic [PosW:0]   pos, e, k, len, len2, vbe, tev, cs;
  logic [PosW+1:0] kv;
  logic            active, fin_hdr_kind_host, fin_hdr_kind_auth;
  kind_e           fkind;

  assign c = in_i.data;
  assign pos = pos_q;
  // result register loads on this edge
  assign res_valid_o = in_fire_i && in_i.last;

  always_comb begin
    pos_d = pos_q; lb_d = lb_q; lines_d = lines_q; ph_d = ph_q; crp_d = crp_q;
    inw_d = inw_q; err_d = err_q; wn_d = wn_q; mf_d = mf_q; ma_d = ma_q; mp_d = mp_q;
    m10_d = m10_q; m20_d = m20_q; kind_d = kind_q; vb_d = vb_q; colon_d = colon_q;
    spf_d = spf_q; host_d = host_q; getok_d = getok_q; w0_d = w0_q; pb_d = pb_q;
    pe_d = pe_q; w2_d = w2_q; te_d = te_q; rk_d = rk_q; ver_d = ver_q;
    hoff_d = hoff_q; hlen_d = hlen_q; aoff_d = aoff_q; alen_d = alen_q;
    e = pos - 1'b1;
    k = '0; len = '0; len2 = '0; vbe = '0; tev = '0; cs = '0; kv = '0;
    fkind = KIND_OTHER; fin_hdr_kind_host = 1'b0; fin_hdr_kind_auth = 1'b0;
    active = !err_q && ph_q != PH_DONE && pos < BufferBytes;
    if (active) begin
      if (crp_q) begin
        crp_d = 1'b0;
        if (c == ChLf) begin
          // close the line ending at the CR
          len = e - lb_q;
          lines_d = lines_q + 1'b1;
          if (ph_q == PH_REQUEST) begin
            rk_d = 2'd0;
            if (wn_q == 2'd2 && getok_q) begin
              len2 = inw_q ? e - w2_q : '0;
              rk_d = 2'd1;
              if (inw_q && mp_q && len2 >= 5) begin
                rk_d = 2'd2;
                if (len2 == 8 && m10_q) ver_d = 2'd0;
                else if (len2 == 8 && m20_q) ver_d = 2'd2;
                else ver_d = 2'd1;
              end
            end
            ph_d = PH_HEADERS;
          end else begin
            if (!colon_q) begin
              fin_hdr_kind_host = mf_q && len == 4;
              fin_hdr_kind_auth = ma_q && len == 13;
              fkind = fin_hdr_kind_host ? KIND_HOST : fin_hdr_kind_auth ? KIND_AUTH
                                                                          : KIND_OTHER;
              vbe = e;
            end else begin
              fkind = kind_q;
              vbe = (vb_q < {1'b0, e}) ? vb_q[PosW:0] : e;
            end
            if (fkind == KIND_HOST) begin
              hoff_d = vbe; hlen_d = e - vbe; host_d = 1'b1;
            end else if (fkind == KIND_AUTH && colon_q) begin
              tev = spf_q ? te_q : e;
              if (mf_q && tev >= vbe && tev - vbe == 5) begin
                cs = ({1'b0, tev} + 1'b1 < {1'b0, e}) ? tev + 1'b1 : e;
                aoff_d = cs; alen_d = e - cs;
              end
            end
          end
          if (len == '0) ph_d = PH_DONE;
          else if (lines_d >= MaxLines) err_d = 1'b1;
          lb_d = pos + 1'b1;
          mf_d = 1'b1; ma_d = 1'b1; kind_d = KIND_OTHER; colon_d = 1'b0;
          spf_d = 1'b0; vb_d = '0; te_d = '0;
        end else begin
          err_d = 1'b1;
        end
      end else if (c == ChCr) begin
        crp_d = 1'b1;
      end else if (ph_q == PH_REQUEST) begin
        if (!inw_q && c == ChSp) begin
          // drop spaces between words
        end else begin
          if (!inw_q) begin
            inw_d = 1'b1;
            if (wn_q == 2'd0) begin
              w0_d = pos; mf_d = 1'b1;
            end else if (wn_q == 2'd1) begin
              pb_d = pos;
            end else begin
              w2_d = pos; mp_d = 1'b1; m10_d = 1'b1; m20_d = 1'b1;
            end
          end
          if (c == ChSp) begin
            inw_d = 1'b0;
            if (wn_q == 2'd0) begin
              getok_d = mf_q && (pos - w0_q == 3);
              wn_d = wn_q + 1'b1;
            end else if (wn_q == 2'd1) begin
              pe_d = pos;
              wn_d = wn_q + 1'b1;
            end else begin
              err_d = 1'b1;
            end
          end else if (wn_q == 2'd0) begin
            k = pos - w0_d;
            if (k >= 3 || c != get_ch(k[1:0])) mf_d = 1'b0;
          end else if (wn_q == 2'd2) begin
            k = pos - w2_d;
            if (k < 5) begin
              if (c != http_ch(k[2:0])) mp_d = 1'b0;
            end else begin
              k = k - 14'd5;
              if (k >= 3) begin
                m10_d = 1'b0; m20_d = 1'b0;
              end else begin
                if (c != (k == 0 ? "1" : k == 1 ? "." : "0")) m10_d = 1'b0;
                if (c != (k == 0 ? "2" : k == 1 ? "." : "0")) m20_d = 1'b0;
              end
            end
          end
        end
      end else begin
        k = pos - lb_q;
        if (!colon_q) begin
          if (c == ChColon) begin
            colon_d = 1'b1;
            if (mf_q && k == 4) kind_d = KIND_HOST;
            else if (ma_q && k == 13) kind_d = KIND_AUTH;
            else kind_d = KIND_OTHER;
            vb_d = {1'b0, pos} + 2'd2;
            mf_d = 1'b1;
          end else begin
            if (k >= 4 || c != host_ch(k[1:0])) mf_d = 1'b0;
            if (k >= 13 || c != auth_ch(k[3:0])) ma_d = 1'b0;
          end
        end else if (kind_q == KIND_AUTH && {1'b0, pos} >= vb_q && !spf_q) begin
          if (c == ChSp) begin
            spf_d = 1'b1; te_d = pos;
          end else begin
            kv = {1'b0, pos} - vb_q;
            if (kv >= 5 || c != basic_ch(kv[2:0])) mf_d = 1'b0;
          end
        end
      end
    end
    if (pos_q < BufferBytes) pos_d = pos_q + 1'b1;

    res_d = '0;
    if (!err_d && !crp_d && lines_d >= 2 && rk_d != 2'd0) begin
      res_d.is_get = 1'b1;
      res_d.path_offset = pb_d[PosW-1:0];
      res_d.path_length = LenW'(pe_d - pb_d);
      if (rk_d == 2'd2) begin
        res_d.request_valid = host_d;
        res_d.version_code = ver_d;
        res_d.host_offset = hoff_d[PosW-1:0];
        res_d.host_length = LenW'(hlen_d);
        res_d.auth_offset = aoff_d[PosW-1:0];
        res_d.auth_length = LenW'(alen_d);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; lb_q <= '0; lines_q <= '0; ph_q <= PH_REQUEST; crp_q <= 1'b0;
      inw_q <= 1'b0; err_q <= 1'b0; wn_q <= '0; mf_q <= 1'b0; ma_q <= 1'b0;
      mp_q <= 1'b0; m10_q <= 1'b0; m20_q <= 1'b0; kind_q <= KIND_OTHER; vb_q <= '0;
      colon_q <= 1'b0; spf_q <= 1'b0; host_q <= 1'b0; getok_q <= 1'b0;
      w0_q <= '0; pb_q <= '0; pe_q <= '0; w2_q <= '0; te_q <= '0; rk_q <= '0;
      ver_q <= '0; hoff_q <= '0; hlen_q <= '0; aoff_q <= '0; alen_q <= '0;
    end else begin
      if (in_fire_i) begin
        if (in_i.last) begin
          pos_q <= '0; lb_q <= '0; lines_q <= '0; ph_q <= PH_REQUEST; crp_q <= 1'b0;
          inw_q <= 1'b0; err_q <= 1'b0; wn_q <= '0; mf_q <= 1'b0; ma_q <= 1'b0;
          mp_q <= 1'b0; m10_q <= 1'b0; m20_q <= 1'b0; kind_q <= KIND_OTHER;
          vb_q <= '0; colon_q <= 1'b0; spf_q <= 1'b0; host_q <= 1'b0; getok_q <= 1'b0;
          w0_q <= '0; pb_q <= '0; pe_q <= '0; w2_q <= '0; te_q <= '0; rk_q <= '0;
          ver_q <= '0; hoff_q <= '0; hlen_q <= '0; aoff_q <= '0; alen_q <= '0;
        end else begin
          pos_q <= pos_d; lb_q <= lb_d; lines_q <= lines_d; ph_q <= ph_d;
          crp_q <= crp_d; inw_q <= inw_d; err_q <= err_d; wn_q <= wn_d;
          mf_q <= mf_d; ma_q <= ma_d; mp_q <= mp_d; m10_q <= m10_d; m20_q <= m20_d;
          kind_q <= kind_d; vb_q <= vb_d; colon_q <= colon_d; spf_q <= spf_d;
          host_q <= host_d; getok_q <= getok_d; w0_q <= w0_d; pb_q <= pb_d;
          pe_q <= pe_d; w2_q <= w2_d; te_q <= te_d; rk_q <= rk_d; ver_q <= ver_d;
          hoff_q <= hoff_d; hlen_q <= hlen_d; aoff_q <= aoff_d; alen_q <= alen_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i && in_i.last) res_o <= res_d;
  end

`ifndef SYNTHESIS
  a_pos_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= BufferBytes) else $error("position past buffer");
  a_lines_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lines_q <= MaxLines) else $error("line count overrun");
  a_cr_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    crp_q |-> (ph_q != PH_DONE && !err_q)) else $error("CR pending outside framing");
`endif
endmodule
`default_nettype wire

// ===== verif/http_request_head_parser_top_tb.sv =====
// Testbench for the HTTP request head parser: stream stimulus, summary prediction and checks.
`timescale 1ns / 1ps
module http_request_head_parser_top_tb;
  import hrhp_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned RandomBytes = 900;
  localparam int unsigned MinRandomRequests = 40;

  // Running parser state kept alongside the block; one summary per buffer.
  class head_scoreboard;
    localparam int unsigned MFirst = 1;
    localparam int unsigned MAuth = 2;
    localparam int unsigned MPrefix = 4;
    localparam int unsigned MV10 = 8;
    localparam int unsigned MV20 = 16;

    string kw_get = "GET";
    string kw_http = "HTTP/";
    string kw_v10 = "1.0";
    string kw_v20 = "2.0";
    string kw_host = "Host";
    string kw_auth = "Authorization";
    string kw_basic = "Basic";

    int unsigned pos, line_beg, lines, word_num, match_bits, val_beg, type_end;
    int unsigned w0_beg, path_beg, path_end, w2_beg, req_kind, version;
    int unsigned host_off, host_len, auth_off, auth_len;
    phase_e phase;
    kind_e kind;
    bit cr_pending, in_word, failed, get_ok, colon_seen, space_seen, host_seen;
    res_t summary_q[$];
    int errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void start_line();
      match_bits = MFirst | MAuth;
      kind = KIND_OTHER;
      colon_seen = 0;
      space_seen = 0;
      val_beg = 0;
      type_end = 0;
    endfunction

    function void clear();
      pos = 0; line_beg = 0; lines = 0; phase = PH_REQUEST;
      cr_pending = 0; in_word = 0; failed = 0; word_num = 0;
      host_off = 0; host_len = 0; auth_off = 0; auth_len = 0;
      get_ok = 0; host_seen = 0;
      w0_beg = 0; path_beg = 0; path_end = 0; w2_beg = 0;
      req_kind = 0; version = 0;
      start_line();
      match_bits = 0;
    endfunction

    function void feed_request(byte unsigned c, int unsigned p);
      int unsigned k;
      if (!in_word && c != ChSp) begin
        in_word = 1;
        if (word_num == 0) begin
          w0_beg = p;
          match_bits = MFirst;
        end else if (word_num == 1) begin
          path_beg = p;
        end else begin
          w2_beg = p;
          match_bits = MPrefix | MV10 | MV20;
        end
      end
      if (!in_word) return;
      if (c == ChSp) begin
        in_word = 0;
        if (word_num == 0) begin
          get_ok = (match_bits & MFirst) != 0 && p - w0_beg == 3;
        end else if (word_num == 1) begin
          path_end = p;
        end else begin
          // a space after the third word kills the whole request
          failed = 1;
          return;
        end
        word_num++;
        return;
      end
      if (word_num == 0) begin
        k = p - w0_beg;
        if (k >= 3 || c != kw_get[k]) match_bits &= ~MFirst;
      end else if (word_num == 2) begin
        k = p - w2_beg;
        if (k < 5) begin
          if (c != kw_http[k]) match_bits &= ~MPrefix;
        end else begin
          k -= 5;
          if (k >= 3) match_bits &= ~(MV10 | MV20);
          else begin
            if (c != kw_v10[k]) match_bits &= ~MV10;
            if (c != kw_v20[k]) match_bits &= ~MV20;
          end
        end
      end
    endfunction

    function void feed_header(byte unsigned c, int unsigned p);
      int unsigned k;
      k = p - line_beg;
      if (!colon_seen) begin
        if (c == ChColon) begin
          colon_seen = 1;
          if ((match_bits & MFirst) != 0 && k == 4) kind = KIND_HOST;
          else if ((match_bits & MAuth) != 0 && k == 13) kind = KIND_AUTH;
          else kind = KIND_OTHER;
          val_beg = p + 2;
          match_bits = MFirst;
        end else begin
          if (k >= 4 || c != kw_host[k]) match_bits &= ~MFirst;
          if (k >= 13 || c != kw_auth[k]) match_bits &= ~MAuth;
        end
      end else if (kind == KIND_AUTH && p >= val_beg && !space_seen) begin
        if (c == ChSp) begin
          space_seen = 1;
          type_end = p;
        end else begin
          k = p - val_beg;
          if (k >= 5 || c != kw_basic[k]) match_bits &= ~MFirst;
        end
      end
    endfunction

    function void finish_request(int unsigned e);
      int unsigned len2;
      len2 = 0;
      req_kind = 0;
      if (word_num != 2 || !get_ok) return;
      if (in_word) len2 = e - w2_beg;
      req_kind = 1;
      if (!(in_word && (match_bits & MPrefix) != 0 && len2 >= 5)) return;
      req_kind = 2;
      if (len2 == 8 && (match_bits & MV10) != 0) version = 0;
      else if (len2 == 8 && (match_bits & MV20) != 0) version = 2;
      else version = 1;
    endfunction

    function void finish_header(int unsigned e);
      int unsigned vb, te, cs;
      if (!colon_seen) begin
        // no colon: whole line is the name, value empty at the line end
        if ((match_bits & MFirst) != 0 && e - line_beg == 4) kind = KIND_HOST;
        else if ((match_bits & MAuth) != 0 && e - line_beg == 13) kind = KIND_AUTH;
        else kind = KIND_OTHER;
        val_beg = e;
      end
      vb = val_beg < e ? val_beg : e;
      if (kind == KIND_HOST) begin
        host_off = vb;
        host_len = e - vb;
        host_seen = 1;
      end else if (kind == KIND_AUTH && colon_seen) begin
        te = space_seen ? type_end : e;
        if ((match_bits & MFirst) != 0 && te >= vb && te - vb == 5) begin
          cs = te + 1 < e ? te + 1 : e;
          auth_off = cs;
          auth_len = e - cs;
        end
      end
    endfunction

    function void end_line(int unsigned e, int unsigned nxt);
      lines++;
      if (phase == PH_REQUEST) begin
        finish_request(e);
        phase = PH_HEADERS;
      end else begin
        finish_header(e);
      end
      if (e == line_beg) phase = PH_DONE;
      else if (lines >= MaxLines) failed = 1;
      line_beg = nxt;
      start_line();
    endfunction

    // Advance on one accepted input byte; queue a summary on the last byte.
    function void note_byte(byte unsigned c, bit last);
      res_t r;
      if (!failed && phase != PH_DONE && pos < BufferBytes) begin
        if (cr_pending) begin
          cr_pending = 0;
          if (c == ChLf) end_line(pos - 1, pos + 1);
          else failed = 1;
        end else if (c == ChCr) begin
          cr_pending = 1;
        end else if (phase == PH_REQUEST) begin
          feed_request(c, pos);
        end else begin
          feed_header(c, pos);
        end
      end
      if (pos < BufferBytes) pos++;
      if (!last) return;
      r = '0;
      if (!failed && !cr_pending && lines >= 2 && req_kind != 0) begin
        r.is_get = 1'b1;
        r.path_offset = path_beg[PosW-1:0];
        r.path_length = LenW'(path_end - path_beg);
        if (req_kind == 2) begin
          r.request_valid = host_seen;
          r.version_code = version[1:0];
          r.host_offset = host_off[PosW-1:0];
          r.host_length = host_len[LenW-1:0];
          r.auth_offset = auth_off[PosW-1:0];
          r.auth_length = auth_len[LenW-1:0];
        end
      end
      summary_q.push_back(r);
      clear();
    endfunction

    task report(string what, int unsigned want, int unsigned got);
      $display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
      errors++;
    endtask

    task check_summary(logic [87:0] d);
      res_t e;
      if (summary_q.size() == 0) begin
        report("unexpected summary", 0, 1);
        return;
      end
      e = summary_q.pop_front();
      if (d[0] !== e.request_valid) report("request_valid", e.request_valid, d[0]);
      if (d[1] !== e.is_get) report("is_get", e.is_get, d[1]);
      if (d[3:2] !== e.version_code) report("version_code", e.version_code, d[3:2]);
      if (d[16:4] !== e.path_offset) report("path_offset", e.path_offset, d[16:4]);
      if (d[30:17] !== e.path_length) report("path_length", e.path_length, d[30:17]);
      if (d[43:31] !== e.host_offset) report("host_offset", e.host_offset, d[43:31]);
      if (d[57:44] !== e.host_length) report("host_length", e.host_length, d[57:44]);
      if (d[70:58] !== e.auth_offset) report("auth_offset", e.auth_offset, d[70:58]);
      if (d[84:71] !== e.auth_length) report("auth_length", e.auth_length, d[84:71]);
      if (d[87:85] !== 3'b000) report("pad bits", 0, d[87:85]);
    endtask
  endclass

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready, s_axis_tlast;
  logic [7:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [87:0] m_axis_tdata;

  head_scoreboard sb;
  byte unsigned buf_q[$];
  int unsigned send_idle_pct, recv_stall_pct, hold_cnt, cycles, sent_bytes, sent_bufs;
  bit hold_req;

  http_request_head_parser_top dut (.*);

  // Free-running clock, 10 ns period.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Watchdog: end the run if the block stops making progress.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off on request to fill the block.
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_cnt = HoldCycles;
      hold_req = 0;
    end
    if (hold_cnt != 0) begin
      hold_cnt--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rst_ni && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor both sides at the edge where the handshake completes.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tdata, s_axis_tlast);
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_summary(m_axis_tdata);
  end

  task set_idling(int unsigned phase_sel);
    case (phase_sel % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
      default: begin send_idle_pct = 8; recv_stall_pct = 8; end
    endcase
  endtask

  task add(string s);
    for (int i = 0; i < s.len(); i++) buf_q.push_back(s[i]);
  endtask

  task add_rand(int unsigned n, int unsigned lo, int unsigned hi);
    for (int i = 0; i < n; i++) buf_q.push_back(byte'($urandom_range(lo, hi)));
  endtask

  // Drive the buffer byte by byte; tlast on the final byte. Valid drops only in random idle
  // gaps and is left high after the buffer; the caller drops it before waiting.
  task send_buffer();
    for (int i = 0; i < buf_q.size(); i++) begin
      while ($urandom_range(0, 99) < send_idle_pct) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= buf_q[i];
      s_axis_tlast <= (i == buf_q.size() - 1);
      @(posedge clk_i);
      while (!s_axis_tready) @(posedge clk_i);
      sent_bytes++;
    end
    buf_q.delete();
    sent_bufs++;
  endtask

  task add_header();
    case ($urandom_range(0, 11))
      0, 1: begin add("Host: "); add_rand($urandom_range(0, 8), 33, 126); end
      2: begin add("Authorization: Basic "); add_rand($urandom_range(0, 10), 33, 126); end
      3: add("Authorization: Bearer xyz");
      4: add("Host");
      5: add("Host:");
      6: begin add("Host:"); add_rand(1, 33, 126); end
      7: add("Authorization: Basic");
      8: add("Authorization: Basic ");
      9: add("Authorization");
      10: begin add("X-Tag: "); add_rand($urandom_range(0, 6), 128, 255); end
      default: begin add("Hos"); add_rand($urandom_range(0, 5), 33, 126); end
    endcase
    add("\r\n");
  endtask

  // Mostly well-formed requests with random content; the rest broken or noise.
  task build_random();
    int unsigned r, n;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      add_rand($urandom_range(1, 30), 0, 255);
      return;
    end
    case ($urandom_range(0, 9))
      0: add("POST");
      1: add("GE");
      2: add("GETX");
      default: add("GET");
    endcase
    if ($urandom_range(0, 3) == 0) add("  ");
    else add(" ");
    add("/");
    add_rand($urandom_range(0, 10), 33, 126);
    case ($urandom_range(0, 19))
      0: ;
      1: add(" ");
      2: add(" HTTP/1.1 x");
      3: add(" HTP/1.1");
      4: add(" HTTP/");
      5: add(" HTTP/1.00");
      6, 7: add(" HTTP/1.0");
      8, 9: add(" HTTP/2.0");
      10: add(" HTTP/3");
      default: add(" HTTP/1.1");
    endcase
    add("\r\n");
    n = $urandom_range(0, 4);
    for (int i = 0; i < n; i++) add_header();
    r = $urandom_range(0, 99);
    if (r < 80) add("\r\n");
    else if (r < 88) add("\r");
    else if (r < 94) add("\rz\n");
    add_rand($urandom_range(0, 4), 0, 255);
    if ($urandom_range(0, 19) == 0) buf_q[$urandom_range(0, buf_q.size() - 1)] =
        byte'($urandom_range(0, 255));
  endtask

  initial begin
    sb = new();
    cycles = 0; hold_cnt = 0; hold_req = 0; sent_bytes = 0; sent_bufs = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    set_idling(0);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed buffers: each special case of the parser once.
    add("GET /index.html HTTP/1.1\r\nHost: example\r\n\r\n"); send_buffer();
    add("GET /a HTTP/1.0\r\nAuthorization: Basic dXNlcg==\r\nHost: h\r\n\r\nxyz");
    send_buffer();
    add("GET / HTTP/2.0\r\nHost\r\n\r\n"); send_buffer();
    add("GET / HTTP/1.1\rX\n\r\n"); send_buffer();
    add("GET / HTTP/1.1\r"); send_buffer();
    add("GET / HTTP/1.1\r\n"); send_buffer();
    add("GET / HTTP/1.1 x\r\n\r\n"); send_buffer();
    add("GET / \r\nHost: a\r\n\r\n"); send_buffer();
    add("POST / HTTP/1.1\r\nHost: a\r\n\r\n"); send_buffer();
    add("GET /a FTP/1.1\r\nHost: a\r\n\r\n"); send_buffer();
    add("GET /x HTTP/1.1\r\nHost:\r\nAuthorization: Basic\r\n\r\n"); send_buffer();
    add("GET / HTTP/1.1\r\nHost: h\r\nX-Y"); send_buffer();
    add("GET /"); buf_q.push_back(8'hff); buf_q.push_back(8'h00);
    add(" HTTP/1.1\r\nHost: a\r\n\r\n"); send_buffer();
    // line limit reached before the empty line
    add("GET / HTTP/1.1\r\n");
    for (int i = 0; i < 520; i++) add("a: b\r\n");
    add("\r\n"); send_buffer();
    // bytes past the buffer size are ignored, the empty line with them
    add("GET / HTTP/1.1\r\nHost: h\r\nX: ");
    for (int i = 0; i < 8300; i++) buf_q.push_back("a");
    add("\r\n\r\n"); send_buffer();
    s_axis_tvalid <= 1'b0;
    s_axis_tlast <= 1'b0;

    // Hold the receiver off so a summary waits and the input stalls behind it.
    while (sb.summary_q.size() != 0) @(posedge clk_i);
    hold_req = 1;
    for (int i = 0; i < 6; i++) begin
      add("GET /p HTTP/1.1\r\nHost: q\r\n\r\n");
      send_buffer();
    end

    // Random part, idling pattern changes every few buffers.
    sent_bytes = 0;
    sent_bufs = 0;
    while (sent_bytes < RandomBytes || sent_bufs < MinRandomRequests) begin
      set_idling(sent_bufs / 5);
      build_random();
      send_buffer();
    end
    s_axis_tvalid <= 1'b0;
    s_axis_tlast <= 1'b0;

    while (sb.summary_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
